[rtl/msdl_pkg.sv]
// msdl_pkg: shared types and constants for the motor speed to drive lines block
// used by msdl_map and motor_speed_to_drive_lines; no dependencies

package msdl_pkg;

   // drive line setting
   typedef enum logic [1:0] {
      MODE_LOW  = 2'd0,
      MODE_HIGH = 2'd1,
      MODE_PWM  = 2'd2
   } mode_type;

   // driver selection
   typedef enum logic [1:0] {
      DRV_ESC       = 2'd0,
      DRV_BRIDGE_8  = 2'd1,
      DRV_BRIDGE_12 = 2'd2,
      DRV_PWM_DIR   = 2'd3
   } driver_type;

   // counter direction hint
   typedef enum logic [1:0] {
      CNT_HOLD = 2'd0,
      CNT_UP   = 2'd1,
      CNT_DOWN = 2'd2
   } count_type;

   // register indexes
   typedef enum logic [1:0] {
      CSR_DRIVER_TYPE    = 2'd0,
      CSR_REVERSE_DIR    = 2'd1,
      CSR_DEAD_ZONE      = 2'd2,
      CSR_DIR_FROM_SPEED = 2'd3
   } csr_index_type;

   localparam int unsigned SPEED_W    = 16;
   localparam int unsigned LAST_W     = 11;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic signed [LAST_W-1:0] LAST_SPEED_RESET = -11'sd1000;

   localparam logic signed [SPEED_W-1:0] SPEED_MAX = 16'sd255;
   localparam logic signed [SPEED_W-1:0] SPEED_MIN = -16'sd255;

   // floor(x * 1000 / 510) == (x * ESC_RECIP) >> ESC_SHIFT for x <= 510
   localparam logic [29:0]  ESC_RECIP = 30'd526345000;
   localparam int unsigned  ESC_SHIFT = 28;
   localparam logic [10:0]  ESC_BASE  = 11'd1000;
   localparam logic [10:0]  ESC_TOP   = 11'd2000;

   // floor(d / 17) == (d * DIV17_RECIP) >> DIV17_SHIFT for d <= 255
   localparam logic [8:0]  DIV17_RECIP = 9'd482;
   localparam int unsigned DIV17_SHIFT = 13;

   typedef struct packed {
      driver_type  drv;
      logic        reverse_dir;
      logic [7:0]  dead_zone;
      logic        dir_from_speed;
   } cfg_type;

   typedef struct packed {
      mode_type    a_mode;
      logic [11:0] a_duty;
      mode_type    b_mode;
      logic [11:0] b_duty;
      mode_type    en_mode;
      logic [7:0]  en_duty;
      logic [10:0] esc_pulse;
      count_type   cdir;
   } drive_type;

endpackage

[rtl/msdl_map.sv]
// msdl_map: combinational speed mapping (clamp, dead zone, per-driver line settings)
// depends on msdl_pkg

module msdl_map (
   input  logic signed [msdl_pkg::SPEED_W-1:0] speed,
   input  logic signed [msdl_pkg::LAST_W-1:0]  last_speed,
   input  msdl_pkg::cfg_type                   cfg,
   output logic                                dup,
   output logic signed [msdl_pkg::LAST_W-1:0]  next_last,
   output msdl_pkg::drive_type                 drive
);

   logic        neg;
   logic        big;
   logic [7:0]  cl_mag;
   logic [7:0]  mag;
   logic        zero;
   logic [8:0]  esc_x;
   logic [38:0] esc_prod;
   logic [9:0]  esc_off;
   logic        s_neg;
   logic [7:0]  inv_duty;
   logic [16:0] div_prod;
   logic [3:0]  div_q;
   logic [11:0] bridge_duty;
   logic [8:0]  mag9;

   assign dup = (speed == {{(msdl_pkg::SPEED_W - msdl_pkg::LAST_W){last_speed[msdl_pkg::LAST_W-1]}},
                           last_speed});

   assign neg    = speed[msdl_pkg::SPEED_W-1];
   assign big    = (speed > msdl_pkg::SPEED_MAX) || (speed < msdl_pkg::SPEED_MIN);
   assign cl_mag = big ? 8'hFF : (neg ? 8'(-speed) : 8'(speed));
   assign zero   = (cl_mag == 8'd0);
   // dead zone raises small nonzero magnitudes
   assign mag    = (!zero && (cl_mag < cfg.dead_zone)) ? cfg.dead_zone : cl_mag;
   assign mag9   = {1'b0, mag};

   assign next_last = neg ? -(msdl_pkg::LAST_W'(mag9)) : msdl_pkg::LAST_W'(mag9);

   // esc: offset of speed + 255 scaled to 0..1000
   assign esc_x    = neg ? (9'd255 - mag9) : (9'd255 + mag9);
   assign esc_prod = 39'(esc_x) * 39'(msdl_pkg::ESC_RECIP);
   assign esc_off  = esc_prod[msdl_pkg::ESC_SHIFT +: 10];

   // bridge: inverted duty, optional 12-bit scaling d*16 + d/17
   assign inv_duty    = 8'd255 - mag;
   assign div_prod    = 17'(inv_duty) * 17'(msdl_pkg::DIV17_RECIP);
   assign div_q       = div_prod[msdl_pkg::DIV17_SHIFT +: 4];
   assign bridge_duty = (cfg.drv == msdl_pkg::DRV_BRIDGE_12) ?
                        ({inv_duty, 4'd0} + 12'(div_q)) : 12'(inv_duty);

   assign s_neg = !zero && (neg ^ cfg.reverse_dir);

   always_comb begin
      drive = '0;
      drive.a_mode  = msdl_pkg::MODE_LOW;
      drive.b_mode  = msdl_pkg::MODE_LOW;
      drive.en_mode = msdl_pkg::MODE_LOW;
      drive.cdir    = msdl_pkg::CNT_HOLD;

      if (cfg.dir_from_speed && !zero) begin
         drive.cdir = neg ? msdl_pkg::CNT_DOWN : msdl_pkg::CNT_UP;
      end

      case (cfg.drv)
         msdl_pkg::DRV_ESC: begin
            drive.esc_pulse = cfg.reverse_dir ? (msdl_pkg::ESC_TOP - 11'(esc_off))
                                              : (msdl_pkg::ESC_BASE + 11'(esc_off));
         end
         msdl_pkg::DRV_BRIDGE_8, msdl_pkg::DRV_BRIDGE_12: begin
            if (zero) begin
               drive.a_mode = msdl_pkg::MODE_HIGH;
               drive.b_mode = msdl_pkg::MODE_HIGH;
            end else if (s_neg) begin
               drive.a_mode = msdl_pkg::MODE_PWM;
               drive.a_duty = bridge_duty;
               drive.b_mode = msdl_pkg::MODE_HIGH;
            end else begin
               drive.a_mode = msdl_pkg::MODE_HIGH;
               drive.b_mode = msdl_pkg::MODE_PWM;
               drive.b_duty = bridge_duty;
            end
         end
         msdl_pkg::DRV_PWM_DIR: begin
            if (zero) begin
               drive.a_mode  = msdl_pkg::MODE_HIGH;
               drive.b_mode  = msdl_pkg::MODE_HIGH;
               drive.en_mode = msdl_pkg::MODE_HIGH;
            end else begin
               drive.a_mode  = s_neg ? msdl_pkg::MODE_LOW : msdl_pkg::MODE_HIGH;
               drive.b_mode  = s_neg ? msdl_pkg::MODE_HIGH : msdl_pkg::MODE_LOW;
               drive.en_mode = msdl_pkg::MODE_PWM;
               drive.en_duty = mag;
            end
         end
         default: begin
            drive.esc_pulse = '0;
         end
      endcase
   end

endmodule

[rtl/motor_speed_to_drive_lines.sv]
// motor_speed_to_drive_lines: top level, speed command to h-bridge / esc drive settings
// depends on msdl_pkg and msdl_map

// Takes one signed speed command per beat and answers with one set of drive-line
// settings, or with nothing when the command equals the last applied speed. The
// block sustains one beat per clock cycle on both channels while rsp_ready stays high.
// A command beat goes into the input register and is mapped from there into the result
// register, which holds it on the rsp_* outputs until rsp_ready takes it.
// While a finished result waits for rsp_ready the input register still takes one more
// beat; req_ready then stays low until the waiting result is taken.
// The repeat check and the last-speed update both happen at the mapping stage, so
// back-to-back commands are compared in order. Configuration registers (driver type,
// reverse, dead zone, counter direction source) are written through csr_* at any
// cycle with no wait and must only change while no command is in flight.

module motor_speed_to_drive_lines (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                csr_we,
   input  logic [1:0]                          csr_index,
   input  logic [msdl_pkg::CSR_DATA_W-1:0]     csr_wdata,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [msdl_pkg::SPEED_W-1:0] req_speed_cmd,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_line_a_mode,
   output logic [11:0]                         rsp_line_a_duty,
   output logic [1:0]                          rsp_line_b_mode,
   output logic [11:0]                         rsp_line_b_duty,
   output logic [1:0]                          rsp_enable_mode,
   output logic [7:0]                          rsp_enable_duty,
   output logic [10:0]                         rsp_esc_pulse_us,
   output logic [1:0]                          rsp_count_direction
);

   // configuration registers
   msdl_pkg::cfg_type cfg_ff;
   msdl_pkg::cfg_type cfg_in;

   // input register
   logic                                s1_valid_ff;
   logic                                s1_valid_in;
   logic signed [msdl_pkg::SPEED_W-1:0] s1_speed_ff;

   // last applied speed
   logic signed [msdl_pkg::LAST_W-1:0]  last_speed_ff;
   logic signed [msdl_pkg::LAST_W-1:0]  last_speed_in;

   // result register
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   msdl_pkg::drive_type                 drive_ff;

   // mapper outputs
   logic                                map_dup;
   logic signed [msdl_pkg::LAST_W-1:0]  map_last;
   msdl_pkg::drive_type                 map_drive;

   logic out_free;
   logic s1_take;
   logic req_take;

   // config write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            msdl_pkg::CSR_DRIVER_TYPE:    cfg_in.drv = msdl_pkg::driver_type'(csr_wdata[1:0]);
            msdl_pkg::CSR_REVERSE_DIR:    cfg_in.reverse_dir    = csr_wdata[0];
            msdl_pkg::CSR_DEAD_ZONE:      cfg_in.dead_zone      = csr_wdata;
            msdl_pkg::CSR_DIR_FROM_SPEED: cfg_in.dir_from_speed = csr_wdata[0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drv            <= msdl_pkg::DRV_BRIDGE_8;
         cfg_ff.reverse_dir    <= 1'b0;
         cfg_ff.dead_zone      <= '0;
         cfg_ff.dir_from_speed <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   msdl_map u_map (
      .speed      (s1_speed_ff),
      .last_speed (last_speed_ff),
      .cfg        (cfg_ff),
      .dup        (map_dup),
      .next_last  (map_last),
      .drive      (map_drive)
   );

   // result slot frees when empty or being taken this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_take   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || s1_take;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      last_speed_in = last_speed_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
      end
      if (out_free) begin
         // a repeated command is dropped here and leaves no result
         rsp_valid_in = s1_valid_ff && !map_dup;
      end
      if (s1_take && !map_dup) begin
         last_speed_in = map_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         last_speed_ff <= msdl_pkg::LAST_SPEED_RESET;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_speed_ff <= last_speed_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_speed_ff <= req_speed_cmd;
      end
      if (s1_take && !map_dup) begin
         drive_ff <= map_drive;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_line_a_mode     = drive_ff.a_mode;
   assign rsp_line_a_duty     = drive_ff.a_duty;
   assign rsp_line_b_mode     = drive_ff.b_mode;
   assign rsp_line_b_duty     = drive_ff.b_duty;
   assign rsp_enable_mode     = drive_ff.en_mode;
   assign rsp_enable_duty     = drive_ff.en_duty;
   assign rsp_esc_pulse_us    = drive_ff.esc_pulse;
   assign rsp_count_direction = drive_ff.cdir;

endmodule

[bench/tb_motor_speed_to_drive_lines.sv]
// tb_motor_speed_to_drive_lines: self-checking bench for the speed command to drive-line mapper
// holds its own mapping predictor in a small ledger class; depends on msdl_pkg and the rtl top

module tb_motor_speed_to_drive_lines;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int SETTLE_CYCLES   = 4;      // two-stage pipe plus margin
   localparam int PHASES          = 8;
   localparam int BEATS_PER_PHASE = 180;

   // predicted drive settings, kept in command order
   class drive_ledger;
      msdl_pkg::cfg_type   cfg;
      int                  last_speed;
      msdl_pkg::drive_type due_settings[$];
      int                  errors;
      int                  commands;
      int                  checked;

      function new();
         cfg.drv            = msdl_pkg::DRV_BRIDGE_8;
         cfg.reverse_dir    = 1'b0;
         cfg.dead_zone      = 8'd0;
         cfg.dir_from_speed = 1'b1;
         last_speed         = -1000;
         errors             = 0;
         commands           = 0;
         checked            = 0;
      endfunction

      function void write_reg(msdl_pkg::csr_index_type idx, logic [7:0] v);
         case (idx)
            msdl_pkg::CSR_DRIVER_TYPE:    cfg.drv = msdl_pkg::driver_type'(v[1:0]);
            msdl_pkg::CSR_REVERSE_DIR:    cfg.reverse_dir = v[0];
            msdl_pkg::CSR_DEAD_ZONE:      cfg.dead_zone = v;
            msdl_pkg::CSR_DIR_FROM_SPEED: cfg.dir_from_speed = v[0];
            default: ;
         endcase
      endfunction

      // map one accepted command beat to the settings it should produce
      function void take_command(logic signed [15:0] cmd);
         int                  spd;
         int                  mag;
         int                  s;
         int                  off;
         int                  duty;
         msdl_pkg::drive_type want;
         commands++;
         spd = cmd;
         // raw command against the stored clamped speed
         if (spd == last_speed) return;
         if (spd > 255) spd = 255;
         if (spd < -255) spd = -255;
         mag = (spd < 0) ? -spd : spd;
         if (spd != 0 && mag < int'(cfg.dead_zone)) begin
            mag = cfg.dead_zone;
            spd = (spd > 0) ? mag : -mag;
         end
         want = '0;
         if (cfg.dir_from_speed)
            want.cdir = (spd > 0) ? msdl_pkg::CNT_UP :
                        ((spd < 0) ? msdl_pkg::CNT_DOWN : msdl_pkg::CNT_HOLD);
         s = cfg.reverse_dir ? -spd : spd;
         case (cfg.drv)
            msdl_pkg::DRV_ESC: begin
               off = ((spd + 255) * 1000) / 510;
               want.esc_pulse = cfg.reverse_dir ? 11'(2000 - off) : 11'(1000 + off);
            end
            msdl_pkg::DRV_BRIDGE_8, msdl_pkg::DRV_BRIDGE_12: begin
               duty = 255 - mag;
               if (cfg.drv == msdl_pkg::DRV_BRIDGE_12) duty = (duty * 4095) / 255;
               if (s == 0) begin
                  want.a_mode = msdl_pkg::MODE_HIGH;
                  want.b_mode = msdl_pkg::MODE_HIGH;
               end else if (s < 0) begin
                  want.a_mode = msdl_pkg::MODE_PWM;
                  want.a_duty = 12'(duty);
                  want.b_mode = msdl_pkg::MODE_HIGH;
               end else begin
                  want.a_mode = msdl_pkg::MODE_HIGH;
                  want.b_mode = msdl_pkg::MODE_PWM;
                  want.b_duty = 12'(duty);
               end
            end
            default: begin
               if (s == 0) begin
                  want.a_mode  = msdl_pkg::MODE_HIGH;
                  want.b_mode  = msdl_pkg::MODE_HIGH;
                  want.en_mode = msdl_pkg::MODE_HIGH;
               end else begin
                  want.a_mode  = (s < 0) ? msdl_pkg::MODE_LOW : msdl_pkg::MODE_HIGH;
                  want.b_mode  = (s < 0) ? msdl_pkg::MODE_HIGH : msdl_pkg::MODE_LOW;
                  want.en_mode = msdl_pkg::MODE_PWM;
                  want.en_duty = 8'(mag);
               end
            end
         endcase
         last_speed = spd;
         due_settings.push_back(want);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            errors++;
            $error("%s expected %0d got %0d", name, want, got);
         end
      endfunction

      function void match_setting(msdl_pkg::drive_type got);
         msdl_pkg::drive_type want;
         if (due_settings.size() == 0) begin
            errors++;
            $error("drive setting beat arrived with none expected");
            return;
         end
         want = due_settings.pop_front();
         checked++;
         compare_field("line_a_mode", want.a_mode, got.a_mode);
         compare_field("line_a_duty", want.a_duty, got.a_duty);
         compare_field("line_b_mode", want.b_mode, got.b_mode);
         compare_field("line_b_duty", want.b_duty, got.b_duty);
         compare_field("enable_mode", want.en_mode, got.en_mode);
         compare_field("enable_duty", want.en_duty, got.en_duty);
         compare_field("esc_pulse_us", want.esc_pulse, got.esc_pulse);
         compare_field("count_direction", want.cdir, got.cdir);
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_we = 1'b0;
   msdl_pkg::csr_index_type csr_index = msdl_pkg::CSR_DRIVER_TYPE;
   logic [7:0]              csr_wdata = 8'd0;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic signed [15:0]      req_speed_cmd = 16'sd0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [1:0]              rsp_line_a_mode;
   logic [11:0]             rsp_line_a_duty;
   logic [1:0]              rsp_line_b_mode;
   logic [11:0]             rsp_line_b_duty;
   logic [1:0]              rsp_enable_mode;
   logic [7:0]              rsp_enable_duty;
   logic [10:0]             rsp_esc_pulse_us;
   logic [1:0]              rsp_count_direction;

   msdl_pkg::drive_type seen;
   drive_ledger         ledger = new();
   int                  cycle_count = 0;
   int                  send_idle_pct = 0;   // chance per cycle that the sender holds off
   int                  recv_stall_pct = 0;  // chance per cycle that the receiver stalls
   int                  settings = 0;

   motor_speed_to_drive_lines i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_speed_cmd       (req_speed_cmd),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_line_a_mode     (rsp_line_a_mode),
      .rsp_line_a_duty     (rsp_line_a_duty),
      .rsp_line_b_mode     (rsp_line_b_mode),
      .rsp_line_b_duty     (rsp_line_b_duty),
      .rsp_enable_mode     (rsp_enable_mode),
      .rsp_enable_duty     (rsp_enable_duty),
      .rsp_esc_pulse_us    (rsp_esc_pulse_us),
      .rsp_count_direction (rsp_count_direction)
   );

   // result ports packed in the same field order as the package struct
   assign seen = {rsp_line_a_mode, rsp_line_a_duty, rsp_line_b_mode, rsp_line_b_duty,
                  rsp_enable_mode, rsp_enable_duty, rsp_esc_pulse_us, rsp_count_direction};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) cycle_count++;

   // receiver side: ready changes on the falling edge only
   always @(negedge clock) rsp_ready = ($urandom_range(99) >= recv_stall_pct);

   // every accepted result beat is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) ledger.match_setting(seen);
   end

   // hang guard
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
   end

   // one register write, mirrored into the predictor
   task automatic write_reg(msdl_pkg::csr_index_type idx, logic [7:0] v);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      ledger.write_reg(idx, v);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic apply_settings(msdl_pkg::driver_type drv, logic rev, logic [7:0] dz,
                                 logic dfs);
      write_reg(msdl_pkg::CSR_DRIVER_TYPE, 8'(drv));
      write_reg(msdl_pkg::CSR_REVERSE_DIR, {7'd0, rev});
      write_reg(msdl_pkg::CSR_DEAD_ZONE, dz);
      write_reg(msdl_pkg::CSR_DIR_FROM_SPEED, {7'd0, dfs});
      settings++;
   endtask

   // sender side: optional hold-off, then one command beat held until taken
   task automatic send_speed(logic signed [15:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_speed_cmd = v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ledger.take_command(v);
      @(negedge clock);
   endtask

   // stop sending, wait for every predicted beat, then let the pipe empty
   // (a repeated command leaves no result but may still be in flight)
   task automatic settle();
      req_valid = 1'b0;
      while (ledger.due_settings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // random speed mix: repeats of the stored speed, full-range noise,
   // values around the dead zone, clamp edges, and the common range
   function automatic logic signed [15:0] pick_speed(int dz);
      int r;
      int mag;
      r = $urandom_range(99);
      if (r < 15) return 16'(ledger.last_speed);
      if (r < 30) return 16'($urandom());
      if (r < 45) begin
         mag = dz + $urandom_range(4) - 2;
         if (mag < 0) mag = 0;
         return $urandom_range(1) ? 16'(mag) : 16'(-mag);
      end
      if (r < 55) begin
         case ($urandom_range(8))
            0: return 16'sd0;
            1: return 16'sd255;
            2: return -16'sd255;
            3: return 16'sd256;
            4: return -16'sd256;
            5: return 16'sd32767;
            6: return -16'sd32768;
            7: return 16'sd1;
            default: return -16'sd1;
         endcase
      end
      return 16'($urandom_range(600) - 300);
   endfunction

   initial begin
      int dz;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset settings, bridge with 8-bit duty
      send_speed(-16'sd1000);   // equals the reset value of the stored speed
      send_speed(16'sd0);
      send_speed(16'sd0);       // repeat, no beat
      send_speed(16'sd32767);
      send_speed(-16'sd32768);
      send_speed(16'sd256);     // clamps to 255
      send_speed(16'sd255);     // raw value matches stored clamp, no beat
      send_speed(-16'sd255);
      send_speed(16'sd1);
      send_speed(-16'sd1);
      settle();

      // esc, reversed, widest dead zone, no counter direction
      apply_settings(msdl_pkg::DRV_ESC, 1'b1, 8'hFF, 1'b0);
      send_speed(16'sd1);
      send_speed(-16'sd1);
      send_speed(16'sd0);
      send_speed(16'sd200);
      settle();

      // bridge with 12-bit duty and a small dead zone
      apply_settings(msdl_pkg::DRV_BRIDGE_12, 1'b0, 8'd10, 1'b1);
      send_speed(16'sd3);
      send_speed(-16'sd3);
      send_speed(16'sd100);
      send_speed(16'sd0);
      settle();

      // pwm plus direction, reversed
      apply_settings(msdl_pkg::DRV_PWM_DIR, 1'b1, 8'd0, 1'b1);
      send_speed(16'sd50);
      send_speed(-16'sd50);
      send_speed(16'sd0);
      send_speed(16'sd300);
      settle();

      // random phases: each driver type twice, varied settings and idling
      for (int p = 0; p < PHASES; p++) begin
         if (p == 1 || p == 6)      dz = 255;
         else if (p == 0 || p == 4) dz = 0;
         else                       dz = $urandom_range(1, 60);
         apply_settings(msdl_pkg::driver_type'(p % 4), 1'((p >> 1) & 1), 8'(dz),
                        1'(p % 3 != 0));
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         for (int i = 0; i < BEATS_PER_PHASE; i++) begin
            // sender pauses mid-phase until everything has drained
            if (p == 3 && i == BEATS_PER_PHASE / 2) settle();
            send_speed(pick_speed(dz));
         end
         settle();
      end

      $display("tb: %0d speed command beats sent, %0d drive setting beats checked",
               ledger.commands, ledger.checked);
      $display("tb: %0d register settings over all driver types, reverse and dead zones",
               settings);
      if (ledger.errors == 0 && ledger.due_settings.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/msdl_pkg.sv
rtl/msdl_map.sv
rtl/motor_speed_to_drive_lines.sv
bench/tb_motor_speed_to_drive_lines.sv
